// ----- hw/rtl/pedd_pkg.sv -----
// shared types, constants and arithmetic helpers of the palette dither
package pedd_pkg;

    localparam int PEDD_MAX_WIDTH   = 2048;
    localparam int PEDD_QUEUE_DEPTH = 4;
    localparam int PEDD_NUM_COLORS  = 5;
    localparam int PEDD_CFG_IDX_W   = 3;
    localparam int PEDD_CFG_DATA_W  = 24;

    // configuration register indexes
    localparam logic [PEDD_CFG_IDX_W-1:0] PEDD_REG_WIDTH  = 3'd0;
    localparam logic [PEDD_CFG_IDX_W-1:0] PEDD_REG_HEIGHT = 3'd1;
    localparam logic [PEDD_CFG_IDX_W-1:0] PEDD_REG_PAL0   = 3'd2;
    localparam logic [PEDD_CFG_IDX_W-1:0] PEDD_REG_PAL1   = 3'd3;
    localparam logic [PEDD_CFG_IDX_W-1:0] PEDD_REG_PAL2   = 3'd4;
    localparam logic [PEDD_CFG_IDX_W-1:0] PEDD_REG_PAL3   = 3'd5;
    localparam logic [PEDD_CFG_IDX_W-1:0] PEDD_REG_PAL4   = 3'd6;

    // diffusion weights in sixteenths
    localparam logic [2:0] PEDD_W_ABOVE_LEFT  = 3'd1;
    localparam logic [2:0] PEDD_W_ABOVE       = 3'd5;
    localparam logic [2:0] PEDD_W_ABOVE_RIGHT = 3'd3;
    localparam logic [2:0] PEDD_W_LEFT        = 3'd7;

    localparam logic [11:0] PEDD_WIDTH_RESET  = 12'd512;
    localparam logic [11:0] PEDD_HEIGHT_RESET = 12'd512;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic signed [8:0] red;
        logic signed [8:0] green;
        logic signed [8:0] blue;
    } t_err3;

    typedef t_rgb [PEDD_NUM_COLORS-1:0] t_pal;

    localparam t_pal PEDD_PAL_RESET = {24'hFF0000, 24'h00FF00, 24'h0000FF,
                                       24'hFFFFFF, 24'h000000};

    typedef struct packed {
        logic first;
        logic abv_ok;
        logic proc;
        logic row_end;
    } t_flags;

    typedef struct packed {
        t_rgb   pix;
        t_flags flags;
    } t_item;

    typedef struct packed {
        t_rgb       quant;
        logic [2:0] idx;
        t_rgb       adj;
        logic       proc;
        logic       row_end;
    } t_res;

    // add c/16 of e to v, round half to even, saturate to a byte
    function automatic logic [7:0] add_share(input logic [7:0] v, input logic [2:0] c,
                                             input logic signed [8:0] e);
        logic signed [13:0] ext_v;
        logic signed [13:0] ext_c;
        logic signed [13:0] ext_e;
        logic signed [13:0] t;
        logic signed [9:0]  q;
        logic               up;
        ext_v = {2'b00, v, 4'b0000};
        ext_c = {11'd0, c};
        ext_e = {{5{e[8]}}, e};
        t     = ext_v + ext_c * ext_e;
        up    = (t[3:0] > 4'd8) || ((t[3:0] == 4'd8) && t[4]);
        q     = t[13:4] + {9'd0, up};
        if (q[9]) begin
            return 8'd0;
        end else if (q[8]) begin
            return 8'd255;
        end
        return q[7:0];
    endfunction

    function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
        logic signed [8:0]  df;
        logic signed [17:0] p;
        df = $signed({1'b0, a}) - $signed({1'b0, b});
        p  = df * df;
        return p[15:0];
    endfunction

    function automatic logic signed [8:0] diff9(input logic [7:0] a, input logic [7:0] b);
        return $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

endpackage

// ----- hw/rtl/pedd_if.sv -----
// pixel stream channel interfaces
interface pedd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;

    modport source (output valid, output in_blue, output in_green, output in_red,
                    input ready);
    modport sink (input valid, input in_blue, input in_green, input in_red,
                  output ready);
endinterface

interface pedd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] quant_blue;
    logic [7:0] quant_green;
    logic [7:0] quant_red;
    logic [2:0] color_index;
    logic [7:0] adjusted_blue;
    logic [7:0] adjusted_green;
    logic [7:0] adjusted_red;
    logic       processed;
    logic       row_end;

    modport source (output valid, output quant_blue, output quant_green,
                    output quant_red, output color_index, output adjusted_blue,
                    output adjusted_green, output adjusted_red, output processed,
                    output row_end, input ready);
    modport sink (input valid, input quant_blue, input quant_green, input quant_red,
                  input color_index, input adjusted_blue, input adjusted_green,
                  input adjusted_red, input processed, input row_end, output ready);
endinterface

// ----- hw/rtl/pedd_front.sv -----
// front end: raster counters and per-pixel classification
module pedd_front
    import pedd_pkg::*;
#(
    parameter int MAX_WIDTH = PEDD_MAX_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    pedd_in_if.sink                      i_pix,
    input  logic [11:0]                  i_width,
    input  logic [11:0]                  i_height,
    input  logic                         i_full,
    output logic                         o_push,
    output t_item                        o_item,
    output logic [$clog2(MAX_WIDTH)-1:0] o_x
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [CW-1:0] r_col;
    logic [11:0]   r_row;
    logic          r_abv_nx;

    logic [WW-1:0] w_eff;
    logic [11:0]   h_eff;
    logic          col_ge;
    logic [12:0]   row1;
    logic [CW-1:0] x;
    logic [11:0]   row;
    logic [WW-1:0] xp1;
    logic [WW:0]   xp2;
    logic          last;
    logic [12:0]   row_p1;

    always_comb begin
        if (i_width < 12'd3) begin
            w_eff = WW'(3);
        end else if (32'(i_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(i_width);
        end
        h_eff  = (i_height < 12'd2) ? 12'd2 : i_height;
        col_ge = WW'(r_col) >= w_eff;
        row1   = {1'b0, r_row} + {12'd0, col_ge};
        x      = col_ge ? '0 : r_col;
        row    = (row1 >= {1'b0, h_eff}) ? 12'd0 : row1[11:0];
        xp1    = WW'(x) + WW'(1);
        xp2    = (WW + 1)'(x) + (WW + 1)'(2);
        last   = xp1 == w_eff;
        row_p1 = {1'b0, row} + 13'd1;
    end

    assign i_pix.ready = !i_full;
    assign o_push      = i_pix.valid && !i_full;

    // above-right share is decided with the geometry seen by the previous word
    always_comb begin
        o_item.pix.blue      = i_pix.in_blue;
        o_item.pix.green     = i_pix.in_green;
        o_item.pix.red       = i_pix.in_red;
        o_item.flags.first   = x == '0;
        o_item.flags.abv_ok  = (x == '0) ? (row != 12'd0) : r_abv_nx;
        o_item.flags.proc    = ({1'b0, row} + 13'd2 <= {1'b0, h_eff}) && (x != '0)
                               && (xp2 <= (WW + 1)'(w_eff));
        o_item.flags.row_end = last;
        o_x                  = x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_abv_nx <= 1'b0;
        end else if (o_push) begin
            r_abv_nx <= (row != 12'd0) && (xp2 < (WW + 1)'(w_eff));
            if (last) begin
                r_col <= '0;
                r_row <= (row_p1 >= {1'b0, h_eff}) ? 12'd0 : row_p1[11:0];
            end else begin
                r_col <= CW'(xp1);
                r_row <= row;
            end
        end
    end

endmodule

// ----- hw/rtl/pedd_fifo.sv -----
// short queue between front end and back end
module pedd_fifo
    import pedd_pkg::*;
#(
    parameter int DW    = 8,
    parameter int DEPTH = PEDD_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_full,
    output logic          o_vld,
    input  logic          i_pop,
    output logic [DW-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [DW-1:0] r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [NW-1:0] r_cnt;
    logic          push_ok;
    logic          pop_ok;

    assign o_full  = r_cnt == NW'(DEPTH);
    assign o_vld   = r_cnt != '0;
    assign o_data  = r_mem[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (pop_ok) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + NW'(1);
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ----- hw/rtl/pedd_back.sv -----
// back end: row error store, diffusion, palette match and output register
module pedd_back
    import pedd_pkg::*;
#(
    parameter int MAX_WIDTH = PEDD_MAX_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    output logic                         o_pop,
    input  t_item                        i_item,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_x,
    input  t_pal                         i_pal,
    pedd_out_if.source                   o_pix
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [$bits(t_err3)-1:0] r_mem [MAX_WIDTH];
    logic [$bits(t_err3)-1:0] r_rd;

    logic          r_s2_vld;
    t_rgb          r_s2_pix;
    t_flags        r_s2_fl;
    logic [CW-1:0] r_s2_x;
    t_err3         r_win0;
    t_err3         r_win1;

    logic          r_c_vld;
    logic          r_c_ph;
    t_rgb          r_v3;
    t_flags        r_c_fl;
    logic [CW-1:0] r_c_x;
    t_rgb          r_adj;
    t_err3         r_left;

    logic          r_out_vld;
    t_res          r_out;

    t_err3         w0;
    t_err3         w1;
    t_err3         w2;
    t_rgb          n_v3;
    t_err3         left;
    t_rgb          n_adj;
    logic [17:0]   pal_dist [PEDD_NUM_COLORS];
    logic [17:0]   best_d;
    logic [2:0]    best;
    t_rgb          pc;
    t_res          n_out;
    t_err3         n_err;

    logic          done;
    logic          c_free;
    logic          s2_mv;
    logic [CW-1:0] ra;

    assign done   = r_c_vld && r_c_ph && (!r_out_vld || o_pix.ready);
    assign c_free = !r_c_vld || done;
    assign s2_mv  = r_s2_vld && c_free;
    assign o_pop  = i_vld && (!r_s2_vld || s2_mv);
    assign ra     = i_x + CW'(1);

    // above-row shares
    always_comb begin
        w0 = r_s2_fl.first ? '0 : r_win0;
        w1 = r_s2_fl.first ? '0 : r_win1;
        w2 = r_s2_fl.abv_ok ? t_err3'(r_rd) : '0;
        n_v3.blue  = add_share(add_share(add_share(r_s2_pix.blue, PEDD_W_ABOVE_LEFT,
                     w0.blue), PEDD_W_ABOVE, w1.blue), PEDD_W_ABOVE_RIGHT, w2.blue);
        n_v3.green = add_share(add_share(add_share(r_s2_pix.green, PEDD_W_ABOVE_LEFT,
                     w0.green), PEDD_W_ABOVE, w1.green), PEDD_W_ABOVE_RIGHT, w2.green);
        n_v3.red   = add_share(add_share(add_share(r_s2_pix.red, PEDD_W_ABOVE_LEFT,
                     w0.red), PEDD_W_ABOVE, w1.red), PEDD_W_ABOVE_RIGHT, w2.red);
    end

    // left share
    always_comb begin
        left        = r_c_fl.first ? '0 : r_left;
        n_adj.blue  = add_share(r_v3.blue, PEDD_W_LEFT, left.blue);
        n_adj.green = add_share(r_v3.green, PEDD_W_LEFT, left.green);
        n_adj.red   = add_share(r_v3.red, PEDD_W_LEFT, left.red);
    end

    // nearest palette entry, lower index wins a tie
    always_comb begin
        for (int i = 0; i < PEDD_NUM_COLORS; i++) begin
            pal_dist[i] = 18'(sq_diff(r_adj.blue, i_pal[i].blue))
                        + 18'(sq_diff(r_adj.green, i_pal[i].green))
                        + 18'(sq_diff(r_adj.red, i_pal[i].red));
        end
        best   = 3'd0;
        best_d = pal_dist[0];
        for (int i = 1; i < PEDD_NUM_COLORS; i++) begin
            if (pal_dist[i] < best_d) begin
                best_d = pal_dist[i];
                best   = 3'(i);
            end
        end
        pc            = i_pal[best];
        n_out.adj     = r_adj;
        n_out.proc    = r_c_fl.proc;
        n_out.row_end = r_c_fl.row_end;
        if (r_c_fl.proc) begin
            n_out.quant = pc;
            n_out.idx   = best;
            n_err.blue  = diff9(r_adj.blue, pc.blue);
            n_err.green = diff9(r_adj.green, pc.green);
            n_err.red   = diff9(r_adj.red, pc.red);
        end else begin
            n_out.quant = '0;
            n_out.idx   = 3'd0;
            n_err       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld  <= 1'b0;
            r_c_vld   <= 1'b0;
            r_c_ph    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_pop) begin
                r_s2_vld <= 1'b1;
            end else if (s2_mv) begin
                r_s2_vld <= 1'b0;
            end
            if (s2_mv) begin
                r_c_vld <= 1'b1;
                r_c_ph  <= 1'b0;
            end else if (done) begin
                r_c_vld <= 1'b0;
            end else if (r_c_vld && !r_c_ph) begin
                r_c_ph <= 1'b1;
            end
            if (done) begin
                r_out_vld <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s2_pix <= i_item.pix;
            r_s2_fl  <= i_item.flags;
            r_s2_x   <= i_x;
        end
        if (s2_mv) begin
            r_v3   <= n_v3;
            r_c_fl <= r_s2_fl;
            r_c_x  <= r_s2_x;
            r_win0 <= w1;
            r_win1 <= w2;
        end
        if (r_c_vld && !r_c_ph) begin
            r_adj <= n_adj;
        end
        if (done) begin
            r_left <= n_err;
            r_out  <= n_out;
        end
    end

    // row error store, write-through on a same-address read
    always_ff @(posedge i_clk) begin
        if (done) begin
            r_mem[r_c_x] <= n_err;
        end
        if (o_pop) begin
            if (done && (r_c_x == ra)) begin
                r_rd <= n_err;
            end else begin
                r_rd <= r_mem[ra];
            end
        end
    end

    assign o_pix.valid          = r_out_vld;
    assign o_pix.quant_blue     = r_out.quant.blue;
    assign o_pix.quant_green    = r_out.quant.green;
    assign o_pix.quant_red      = r_out.quant.red;
    assign o_pix.color_index    = r_out.idx;
    assign o_pix.adjusted_blue  = r_out.adj.blue;
    assign o_pix.adjusted_green = r_out.adj.green;
    assign o_pix.adjusted_red   = r_out.adj.red;
    assign o_pix.processed      = r_out.proc;
    assign o_pix.row_end        = r_out.row_end;

endmodule

// ----- hw/rtl/palette_error_diffusion_dither.sv -----
// top level of the palette error-diffusion dither
//
// i_pix takes raw RGB pixels in raster order, one word per valid/ready
// handshake. o_pix gives one word per input pixel, in the same order: the
// chosen palette color and index, the channels after diffusion, the
// processed flag and the row end flag. Geometry and the five palette colors
// are written over i_cfg_we/i_cfg_idx/i_cfg_data while the block is idle.
// An accepted pixel is registered in the queue, in each back end stage and
// in the output register. A pixel enters the loop that turns the left
// neighbor's error into the next pixel's adjusted value and palette
// match only as the one before it leaves. Input words are taken every
// cycle into a 4-word queue until it fills, so the source sees ready even
// while the output waits. When o_pix.ready is low the output word holds,
// the back end halts and the queue fills, after which i_pix.ready drops.
// Reset clears counters, queue and valid flags and loads the default
// geometry and palette; no clearing pass is run on the row error store.
module palette_error_diffusion_dither
    import pedd_pkg::*;
#(
    parameter int MAX_WIDTH = PEDD_MAX_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    pedd_in_if.sink                    i_pix,
    pedd_out_if.source                 o_pix,
    input  logic                       i_cfg_we,
    input  logic [PEDD_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [PEDD_CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int DW = $bits(t_item) + CW;

    logic [11:0]   r_width;
    logic [11:0]   r_height;
    t_pal          r_pal;

    logic          full;
    logic          push;
    t_item         f_item;
    logic [CW-1:0] f_x;
    logic          q_vld;
    logic          pop;
    logic [DW-1:0] q_data;
    t_item         b_item;
    logic [CW-1:0] b_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= PEDD_WIDTH_RESET;
            r_height <= PEDD_HEIGHT_RESET;
            r_pal    <= PEDD_PAL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                PEDD_REG_WIDTH:  r_width  <= i_cfg_data[11:0];
                PEDD_REG_HEIGHT: r_height <= i_cfg_data[11:0];
                PEDD_REG_PAL0:   r_pal[0] <= t_rgb'(i_cfg_data);
                PEDD_REG_PAL1:   r_pal[1] <= t_rgb'(i_cfg_data);
                PEDD_REG_PAL2:   r_pal[2] <= t_rgb'(i_cfg_data);
                PEDD_REG_PAL3:   r_pal[3] <= t_rgb'(i_cfg_data);
                PEDD_REG_PAL4:   r_pal[4] <= t_rgb'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    pedd_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pix    (i_pix),
        .i_width  (r_width),
        .i_height (r_height),
        .i_full   (full),
        .o_push   (push),
        .o_item   (f_item),
        .o_x      (f_x)
    );

    pedd_fifo #(
        .DW    (DW),
        .DEPTH (PEDD_QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_item, f_x}),
        .o_full  (full),
        .o_vld   (q_vld),
        .i_pop   (pop),
        .o_data  (q_data)
    );

    assign b_item = t_item'(q_data[DW-1:CW]);
    assign b_x    = q_data[CW-1:0];

    pedd_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (q_vld),
        .o_pop   (pop),
        .i_item  (b_item),
        .i_x     (b_x),
        .i_pal   (r_pal),
        .o_pix   (o_pix)
    );

endmodule

// ----- hw/rtl/pedd_checker.sv -----
// output stream checks, bound to the top level
module pedd_checker
    import pedd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    pedd_out_if.source i_mon
);

    a_border_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mon.valid && !i_mon.processed |-> i_mon.quant_blue == 8'd0
            && i_mon.quant_green == 8'd0 && i_mon.quant_red == 8'd0
            && i_mon.color_index == 3'd0)
        else $error("border word carries a palette color");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mon.valid |-> i_mon.color_index <= 3'(PEDD_NUM_COLORS - 1))
        else $error("color index beyond palette");

    a_last_col_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mon.valid && i_mon.processed |-> !i_mon.row_end)
        else $error("last pixel of a row was quantized");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mon.valid && !i_mon.ready |=> i_mon.valid
            && $stable({i_mon.quant_blue, i_mon.quant_green, i_mon.quant_red,
                        i_mon.color_index, i_mon.adjusted_blue, i_mon.adjusted_green,
                        i_mon.adjusted_red, i_mon.processed, i_mon.row_end}))
        else $error("output word changed while stalled");

endmodule

bind palette_error_diffusion_dither pedd_checker u_pedd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_mon   (o_pix)
);
